FILE: design/assert_macros.svh
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("assertion failed");
`define ASSERT_CLK_NR(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_CLK_NR(label, clk, prop)
`endif
`endif

FILE: design/gfr_pkg.sv
// Shared types and constants of the gimbal frame rotation unit.
`timescale 1ns / 1ps
package gfr_pkg;
  localparam int TRIG_W = 17;
  localparam int ENTRY_W = 32;
  localparam logic signed [31:0] POLY [6] = '{
    -32'sd3864, 32'sd172272, -32'sd5026995, 32'sd85569306, -32'sd693598668,
    32'sd1686629713
  };
  localparam int QDEPTH = 16;
  localparam int QPTR_W = 4;
endpackage

FILE: design/gimbal_frame_rotation_unit.sv
// Top level of the gimbal frame rotation unit.
`timescale 1ns / 1ps
// Rotates a 3D point by pitch and yaw between turret and world frames.
// Input stream s_axis: tdata carries coord_x, coord_y, coord_z, pitch_angle,
// yaw_angle; tuser carries action (0 turret to world, 1 the transpose).
// Output stream m_axis: tdata carries rot_x, rot_y, rot_z; tuser is clipped.
// One beat is accepted per cycle when the output is not stalled. A beat
// passes nine front stages (sine polynomial and quadrant fold), a sixteen
// entry queue that it can leave the cycle after it is written, three back
// stages (entries, products, sum and rounding) and an output register.
// s_axis_tready depends only on a count of beats held in the front end and
// the queue. Up to sixteen may be held, so input runs at full rate while
// the output is taken. While m_axis_tvalid is high and m_axis_tready is
// low, the back end and the output register hold; the front end keeps
// running until sixteen beats are held, then input stalls.
// Reset empties all pipelines and the queue; no other state is kept.
module gimbal_frame_rotation_unit #(
  parameter int COORD_WIDTH = 32,
  parameter int ANGLE_WIDTH = 16,
  parameter int DW = ((3 * COORD_WIDTH + 2 * ANGLE_WIDTH + 7) / 8) * 8,
  parameter int OW = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // coord_x, coord_y, coord_z, pitch_angle, yaw_angle from bit 0 up
  input  logic [DW-1:0] s_axis_tdata,
  // action
  input  logic s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // rot_x, rot_y, rot_z from bit 0 up
  output logic [OW-1:0] m_axis_tdata,
  // clipped
  output logic m_axis_tuser
);
  import gfr_pkg::*;
  `include "assert_macros.svh"
  localparam int CW3 = 3 * COORD_WIDTH;
  localparam int QW = CW3 + 1 + 4 * TRIG_W;
  // Front pipeline depth, used to count beats in flight for the credit check.
  localparam int FRONT_LAT = 9;

  logic f_valid;
  logic [CW3:0] f_pay;
  logic signed [TRIG_W-1:0] sp, cp, sy, cy;
  logic [QW-1:0] q_rdata;
  logic q_empty, q_rd, b_en, b_valid;
  logic [QPTR_W:0] q_count;
  logic [CW3:0] b_pay;
  logic [FRONT_LAT-1:0] infl;
  logic [4:0] inflight;

  // Back end advances while its output slot is free or being taken.
  assign b_en = !m_axis_tvalid || m_axis_tready;
  assign q_rd = b_en && !q_empty;

  gfr_front #(.COORD_WIDTH(COORD_WIDTH), .ANGLE_WIDTH(ANGLE_WIDTH), .PAY_W(CW3 + 1)) u_front (
    .clk, .rst, .en(1'b1),
    .in_valid(s_axis_tvalid && s_axis_tready),
    .in_pay({s_axis_tuser, s_axis_tdata[CW3-1:0]}),
    .pitch(s_axis_tdata[CW3 +: ANGLE_WIDTH]),
    .yaw(s_axis_tdata[CW3 + ANGLE_WIDTH +: ANGLE_WIDTH]),
    .out_valid(f_valid), .out_pay(f_pay), .sp, .cp, .sy, .cy
  );

  // Credits: items inside the front pipe plus queue occupancy do not exceed depth.
  always_ff @(posedge clk) begin
    if (rst) infl <= '0;
    else infl <= {infl[FRONT_LAT-2:0], s_axis_tvalid && s_axis_tready};
  end
  assign inflight = 5'($countones(infl));

  gfr_queue #(.W(QW)) u_queue (
    .clk, .rst, .wr(f_valid), .wdata({f_pay, sp, cp, sy, cy}),
    .rd(q_rd), .rdata(q_rdata), .empty(q_empty), .count(q_count)
  );

  // The front has no stall, so input waits until a queue slot is reserved.
  logic [5:0] reserved;
  logic [5:0] fq_cnt;
  always_ff @(posedge clk) begin
    if (rst) fq_cnt <= '0;
    else fq_cnt <= fq_cnt + 6'(s_axis_tvalid && s_axis_tready) - 6'(q_rd);
  end
  assign reserved = fq_cnt;
  assign s_axis_tready = (reserved < 6'(QDEPTH));

  gfr_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk, .rst, .en(b_en), .in_valid(q_rd),
    .inv(q_rdata[QW-1]), .coords(q_rdata[4*TRIG_W +: CW3]),
    .sp(q_rdata[3*TRIG_W +: TRIG_W]), .cp(q_rdata[2*TRIG_W +: TRIG_W]),
    .sy(q_rdata[TRIG_W +: TRIG_W]), .cy(q_rdata[0 +: TRIG_W]),
    .out_valid(b_valid), .out_pay(b_pay)
  );

  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (b_en) m_axis_tvalid <= b_valid;
  end
  always_ff @(posedge clk) begin
    if (b_en) begin
      m_axis_tdata <= OW'(b_pay[CW3-1:0]);
      m_axis_tuser <= b_pay[CW3];
    end
  end

  `ASSERT_CLK(a_no_overflow, clk, rst, !(f_valid && q_count == (QPTR_W+1)'(QDEPTH) && !q_rd))
  `ASSERT_CLK(a_credit, clk, rst, fq_cnt <= 6'(QDEPTH) && 5'(q_count) + inflight <= 5'(fq_cnt))
  `ASSERT_CLK(a_no_underflow, clk, rst, !(q_rd && q_empty))
endmodule

FILE: design/gfr_front.sv
// Front end: quarter sine polynomial pipeline and quadrant fold for both angles.
`timescale 1ns / 1ps
module gfr_front #(
  parameter int COORD_WIDTH = 32,
  parameter int ANGLE_WIDTH = 16,
  parameter int PAY_W = 3 * COORD_WIDTH + 1
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic [PAY_W-1:0] in_pay,
  input  logic [ANGLE_WIDTH-1:0] pitch,
  input  logic [ANGLE_WIDTH-1:0] yaw,
  output logic out_valid,
  output logic [PAY_W-1:0] out_pay,
  output logic signed [gfr_pkg::TRIG_W-1:0] sp,
  output logic signed [gfr_pkg::TRIG_W-1:0] cp,
  output logic signed [gfr_pkg::TRIG_W-1:0] sy,
  output logic signed [gfr_pkg::TRIG_W-1:0] cy
);
  import gfr_pkg::*;
  // Stages: 0 load t, 1 u, 2..6 Horner steps, 7 times t, 8 round and fold.
  localparam int NST = 9;
  localparam int QW = ANGLE_WIDTH - 2;
  // Q2.30 values stay below 2^31 in magnitude, so 33 signed bits hold them.
  localparam int VW = 33;
  localparam logic [QW:0] QUARTER = {1'b1, {QW{1'b0}}};

  logic [NST-1:0] vld;
  logic [PAY_W-1:0] pay [NST];
  logic [1:0] qd [8][2];
  logic signed [VW-1:0] t [7][4];
  logic signed [VW-1:0] u [1:5][4];
  logic signed [VW-1:0] p [1:7][4];
  logic signed [TRIG_W-1:0] fin [4];

  function automatic logic signed [VW-1:0] fshift30(input logic signed [2*VW-1:0] v);
    fshift30 = v[VW+29:30];
  endfunction

  function automatic logic signed [TRIG_W-1:0] rnd(input logic signed [VW-1:0] v);
    logic signed [VW-1:0] r;
    r = (v + VW'(16384)) >>> 15;
    if (r < 0) rnd = '0;
    else if (r > VW'(32768)) rnd = TRIG_W'(32768);
    else rnd = r[TRIG_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pay[0] <= in_pay;
      qd[0][0] <= pitch[ANGLE_WIDTH-1 -: 2];
      qd[0][1] <= yaw[ANGLE_WIDTH-1 -: 2];
      // lanes: pitch s, pitch c, yaw s, yaw c
      t[0][0] <= VW'(pitch[QW-1:0]) << (32 - ANGLE_WIDTH);
      t[0][1] <= VW'(QUARTER - {1'b0, pitch[QW-1:0]}) << (32 - ANGLE_WIDTH);
      t[0][2] <= VW'(yaw[QW-1:0]) << (32 - ANGLE_WIDTH);
      t[0][3] <= VW'(QUARTER - {1'b0, yaw[QW-1:0]}) << (32 - ANGLE_WIDTH);
      for (int s = 1; s < NST; s++) pay[s] <= pay[s-1];
      for (int s = 1; s < 8; s++) qd[s] <= qd[s-1];
      for (int l = 0; l < 4; l++) begin
        for (int s = 1; s < 7; s++) t[s][l] <= t[s-1][l];
        for (int s = 2; s < 6; s++) u[s][l] <= u[s-1][l];
        u[1][l] <= fshift30(t[0][l] * t[0][l]);
        p[1][l] <= VW'(POLY[0]);
        for (int k = 1; k < 6; k++)
          p[k+1][l] <= VW'(POLY[k]) + fshift30(p[k][l] * u[k][l]);
        p[7][l] <= fshift30(p[6][l] * t[6][l]);
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 4; l++) fin[l] = rnd(p[7][l]);
  end

  function automatic logic signed [2*TRIG_W-1:0] fold(input logic [1:0] q,
      input logic signed [TRIG_W-1:0] s, input logic signed [TRIG_W-1:0] c);
    case (q)
      2'd0: fold = {s, c};
      2'd1: fold = {c, -s};
      2'd2: fold = {-s, -c};
      default: fold = {-c, s};
    endcase
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      {sp, cp} <= fold(qd[7][0], fin[0], fin[1]);
      {sy, cy} <= fold(qd[7][1], fin[2], fin[3]);
    end
  end

  assign out_valid = vld[NST-1];
  assign out_pay = pay[NST-1];
endmodule

FILE: design/gfr_queue.sv
// Small queue between the front end and the matrix back end.
`timescale 1ns / 1ps
module gfr_queue #(
  parameter int W = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  logic [W-1:0] wdata,
  input  logic rd,
  output logic [W-1:0] rdata,
  output logic empty,
  output logic [gfr_pkg::QPTR_W:0] count
);
  import gfr_pkg::*;
  logic [W-1:0] mem [QDEPTH];
  logic [QPTR_W-1:0] wp, rp;

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (wr) wp <= wp + 1'b1;
      if (rd) rp <= rp + 1'b1;
      count <= count + (QPTR_W+1)'(wr) - (QPTR_W+1)'(rd);
    end
  end

  assign rdata = mem[rp];
  assign empty = (count == '0);
endmodule

FILE: design/gfr_back.sv
// Back end: matrix entries, nine products, sums, rounding and saturation.
`timescale 1ns / 1ps
module gfr_back #(
  parameter int COORD_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic inv,
  input  logic [3*COORD_WIDTH-1:0] coords,
  input  logic signed [gfr_pkg::TRIG_W-1:0] sp,
  input  logic signed [gfr_pkg::TRIG_W-1:0] cp,
  input  logic signed [gfr_pkg::TRIG_W-1:0] sy,
  input  logic signed [gfr_pkg::TRIG_W-1:0] cy,
  output logic out_valid,
  output logic [3*COORD_WIDTH:0] out_pay
);
  import gfr_pkg::*;
  localparam int PW = COORD_WIDTH + ENTRY_W;
  localparam int SW = PW + 2;
  localparam logic signed [SW-1:0] HI = SW'((64'sd1 <<< (COORD_WIDTH - 1)) - 1);
  localparam logic signed [SW-1:0] LO = -HI - 1;

  logic [2:0] vld;
  logic signed [ENTRY_W-1:0] m [3][3];
  logic signed [COORD_WIDTH-1:0] v1 [3];
  logic signed [PW-1:0] pr [3][3];
  logic signed [SW-1:0] acc [3];
  logic signed [ENTRY_W-1:0] e [3][3];
  logic [2:0] clip;
  logic [COORD_WIDTH-1:0] r [3];

  always_comb begin
    e[0][0] = ENTRY_W'(cy) <<< 15;
    e[0][1] = -(ENTRY_W'(sp) * ENTRY_W'(sy));
    e[0][2] = -(ENTRY_W'(cp) * ENTRY_W'(sy));
    e[1][0] = '0;
    e[1][1] = ENTRY_W'(cp) <<< 15;
    e[1][2] = -(ENTRY_W'(sp) <<< 15);
    e[2][0] = ENTRY_W'(sy) <<< 15;
    e[2][1] = ENTRY_W'(sp) * ENTRY_W'(cy);
    e[2][2] = ENTRY_W'(cp) * ENTRY_W'(cy);
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[1:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        v1[i] <= coords[i*COORD_WIDTH +: COORD_WIDTH];
        for (int j = 0; j < 3; j++) m[i][j] <= inv ? e[j][i] : e[i][j];
      end
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          pr[i][j] <= PW'(v1[j]) * PW'(m[i][j]);
      for (int i = 0; i < 3; i++)
        acc[i] <= (SW'(pr[i][0]) + SW'(pr[i][1]) + SW'(pr[i][2])
                   + (SW'(1) <<< 29)) >>> 30;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      clip[i] = (acc[i] > HI) || (acc[i] < LO);
      r[i] = (acc[i] > HI) ? HI[COORD_WIDTH-1:0] :
             (acc[i] < LO) ? LO[COORD_WIDTH-1:0] : acc[i][COORD_WIDTH-1:0];
    end
  end

  assign out_valid = vld[2];
  assign out_pay = {|clip, r[2], r[1], r[0]};
endmodule
